// File: design/fdm_pkg.sv
// shared types and constants for the multichannel decimating fir
package fdm_pkg;

	localparam int DATA_W      = 32;
	localparam int REG_ADDR_W  = 4;
	localparam int SHIFT_W     = 3;
	localparam int CH_CNT_W    = 4;
	localparam int TAP_CNT_W   = 7;
	localparam int PHASE_W     = 7;
	localparam int IDX_W       = 6;
	localparam int COEF_W      = 18;
	localparam int SAMPLE_W    = 16;
	localparam int OUT_CH_W    = 3;
	localparam int PROD_W      = COEF_W + SAMPLE_W;
	localparam int ACC_W       = 42;
	localparam int YC_W        = 8;
	localparam int ROUND_SHIFT = 17;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [SHIFT_W-1:0]   RST_SHIFT = 3'd2;
	localparam logic [CH_CNT_W-1:0]  RST_CHANS = 4'd2;
	localparam logic [TAP_CNT_W-1:0] RST_TAPS  = 7'd64;

	typedef enum logic [1:0] {
		REG_DECIM = 2'd0,
		REG_CHANS = 2'd1,
		REG_TAPS  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SHIFT_W-1:0]   decimation_shift;
		logic [CH_CNT_W-1:0]  channel_count;
		logic [TAP_CNT_W-1:0] tap_count;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_WRITE,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// File: design/fdm_if.sv
// valid/ready channel interfaces for input items and results
interface fdm_item_if;
	import fdm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [IDX_W-1:0]           coef_index;
	logic signed [COEF_W-1:0]   coef_value;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       first_of_stream;

	modport source (
		output valid, operation, coef_index, coef_value, sample, first_of_stream,
		input  ready
	);
	modport sink (
		input  valid, operation, coef_index, coef_value, sample, first_of_stream,
		output ready
	);
endinterface

interface fdm_result_if;
	import fdm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filtered;
	logic [OUT_CH_W-1:0]        out_channel;

	modport source (
		output valid, filtered, out_channel,
		input  ready
	);
	modport sink (
		input  valid, filtered, out_channel,
		output ready
	);
endinterface

// File: design/fir_decimator_multichannel.sv
// top level: sequencer, tap and history memories, result register
// a coefficient load is written while the sequencer stays idle; a sample with no output passes through the write state
// a sample that starts a stream, and each sample until the channel position wraps, first fills its channel history
// a sample with output is accumulated over the effective tap count in the single shared mac
// after reset a clearing pass zeroes all TAPS*CHANNELS history entries, item.ready low
// configuration resets to shift 2, two channels, 64 taps
module fir_decimator_multichannel #(
	parameter int TAPS     = 64,
	parameter int CHANNELS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdm_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [fdm_pkg::DATA_W-1:0]      pwdata,
	output logic [fdm_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	fdm_item_if.sink                        item,
	fdm_result_if.source                    result
);
	import fdm_pkg::*;

	localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int PW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HD = TAPS * CHANNELS;
	localparam int HW = (HD > 1) ? $clog2(HD) : 1;
	localparam int CW = (PW >= CH_CNT_W) ? PW + 1 : CH_CNT_W + 1;

	cfg_t     cfg;
	state_t   state_q, state_d;
	mac_ctl_t mac_ctl;
	logic     mac_busy;
	logic signed [SAMPLE_W-1:0] mac_res;

	logic [PW-1:0]      pos_q;
	logic [TW-1:0]      head_q;
	logic [PHASE_W-1:0] phase_q;
	logic               priming_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic [PW-1:0]      chan_q;
	logic [HW-1:0]      base_q;
	logic [TW-1:0]      cur_head_q;
	logic               emit_q;

	logic [TW-1:0]      slot_q;
	logic [YC_W-1:0]    ycnt_q;
	logic [HW-1:0]      clr_q;

	logic signed [COEF_W-1:0]   tap_mem [TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [HD];
	logic signed [COEF_W-1:0]   tap_rd_q;
	logic signed [SAMPLE_W-1:0] hist_rd_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic [OUT_CH_W-1:0]        ochan_q;

	logic [CW-1:0]        chans_c;
	logic [TAP_CNT_W-1:0] ntaps_c;
	logic [PHASE_W-1:0]   pmask_c;
	logic [PW-1:0]        pos_eff;
	logic [PHASE_W-1:0]   phase_eff;
	logic                 prim_eff;
	logic [CW-1:0]        pos_inc_c;
	logic                 wrap_c;
	logic                 accept_c, samp_c, load_c;
	logic                 fill_last_c, clr_last_c;
	logic                 out_free_c, out_load_c;
	logic                 hw_en;
	logic [HW-1:0]        hw_addr, hr_addr;
	logic signed [SAMPLE_W-1:0] hw_data;

	fdm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fdm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.tap_rd  (tap_rd_q),
		.hist_rd (hist_rd_q),
		.busy    (mac_busy),
		.rounded (mac_res)
	);

	// effective configuration and stream position for the incoming sample
	always_comb begin
		if (cfg.channel_count == '0) begin
			chans_c = CW'(1);
		end else if (CW'(cfg.channel_count) > CW'(CHANNELS)) begin
			chans_c = CW'(CHANNELS);
		end else begin
			chans_c = CW'(cfg.channel_count);
		end
		if (int'(cfg.tap_count) > TAPS) begin
			ntaps_c = TAP_CNT_W'(TAPS);
		end else begin
			ntaps_c = cfg.tap_count;
		end
		pmask_c = ~({PHASE_W{1'b1}} << cfg.decimation_shift);
		pos_eff = item.first_of_stream ? '0 : pos_q;
		if (CW'(pos_eff) >= chans_c) begin
			pos_eff = '0;
		end
		phase_eff = item.first_of_stream ? '0 : (phase_q & pmask_c);
		prim_eff  = item.first_of_stream || priming_q;
		pos_inc_c = CW'(pos_eff) + CW'(1);
		wrap_c    = pos_inc_c >= chans_c;
	end

	assign accept_c    = item.valid && item.ready;
	assign samp_c      = accept_c && (item.operation == OP_SAMPLE);
	assign load_c      = accept_c && (item.operation == OP_LOAD);
	assign fill_last_c = slot_q == TW'(TAPS - 1);
	assign clr_last_c  = clr_q == HW'(HD - 1);
	assign out_free_c  = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last_c) state_d = ST_IDLE;
			ST_IDLE: begin
				if (samp_c) state_d = prim_eff ? ST_FILL : ST_WRITE;
			end
			ST_FILL: begin
				if (fill_last_c) state_d = emit_q ? ST_MAC : ST_IDLE;
			end
			ST_WRITE: state_d = emit_q ? ST_MAC : ST_IDLE;
			ST_MAC:   if (!mac_ctl.issue) state_d = ST_DRAIN;
			ST_DRAIN: if (!mac_busy) state_d = ST_DONE;
			ST_DONE:  if (out_free_c) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item.ready    = 1'b0;
		hw_en         = 1'b0;
		hw_addr       = base_q + HW'(slot_q);
		hw_data       = x_q;
		hr_addr       = base_q + HW'(slot_q);
		mac_ctl.clear = 1'b0;
		mac_ctl.issue = 1'b0;
		out_load_c    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				hw_en   = 1'b1;
				hw_addr = clr_q;
				hw_data = '0;
			end
			ST_IDLE: item.ready = 1'b1;
			ST_FILL: begin
				hw_en         = 1'b1;
				mac_ctl.clear = 1'b1;
			end
			ST_WRITE: begin
				hw_en         = 1'b1;
				hw_addr       = base_q + HW'(cur_head_q);
				mac_ctl.clear = 1'b1;
			end
			ST_MAC:   mac_ctl.issue = YC_W'(ntaps_c) > ycnt_q;
			ST_DRAIN: ;
			ST_DONE:  out_load_c = out_free_c;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			pos_q     <= '0;
			head_q    <= '0;
			phase_q   <= '0;
			priming_q <= 1'b0;
			slot_q    <= '0;
			ycnt_q    <= '0;
			clr_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + HW'(1);
			end
			if (samp_c) begin
				slot_q <= '0;
				if (wrap_c) begin
					pos_q     <= '0;
					head_q    <= (head_q == TW'(TAPS - 1)) ? '0 : head_q + TW'(1);
					phase_q   <= (phase_eff + PHASE_W'(1)) & pmask_c;
					priming_q <= 1'b0;
				end else begin
					pos_q     <= PW'(pos_inc_c);
					phase_q   <= phase_eff;
					priming_q <= prim_eff;
				end
			end else if (state_q == ST_FILL) begin
				slot_q <= fill_last_c ? cur_head_q : slot_q + TW'(1);
			end else if (state_q == ST_WRITE) begin
				slot_q <= cur_head_q;
			end else if (mac_ctl.issue) begin
				slot_q <= (slot_q == '0) ? TW'(TAPS - 1) : slot_q - TW'(1);
			end
			if (state_q != ST_MAC) begin
				ycnt_q <= '0;
			end else if (mac_ctl.issue) begin
				ycnt_q <= ycnt_q + YC_W'(1);
			end
		end
	end

	// per-transaction capture
	always_ff @(posedge clk) begin
		if (samp_c) begin
			x_q        <= item.sample;
			chan_q     <= pos_eff;
			base_q     <= HW'(pos_eff) * HW'(TAPS);
			cur_head_q <= head_q;
			emit_q     <= phase_eff == '0;
		end
	end

	// coefficient store
	always_ff @(posedge clk) begin
		if (load_c && (int'(item.coef_index) < TAPS)) begin
			tap_mem[TW'(item.coef_index)] <= item.coef_value;
		end
		tap_rd_q <= tap_mem[ycnt_q[TW-1:0]];
	end

	// sample history, one row of TAPS per channel
	always_ff @(posedge clk) begin
		if (hw_en) begin
			hist_mem[hw_addr] <= hw_data;
		end
		hist_rd_q <= hist_mem[hr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_c) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_c) begin
			filtered_q <= mac_res;
			ochan_q    <= OUT_CH_W'(chan_q);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.filtered    = filtered_q;
	assign result.out_channel = ochan_q;

endmodule

// File: design/fdm_apb_regs.sv
// apb configuration registers
module fdm_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdm_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [fdm_pkg::DATA_W-1:0]      pwdata,
	output logic [fdm_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	output fdm_pkg::cfg_t                   cfg
);
	import fdm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decimation_shift <= RST_SHIFT;
			cfg_q.channel_count    <= RST_CHANS;
			cfg_q.tap_count        <= RST_TAPS;
		end else if (wr_en) begin
			unique case (idx)
				REG_DECIM: cfg_q.decimation_shift <= pwdata[SHIFT_W-1:0];
				REG_CHANS: cfg_q.channel_count    <= pwdata[CH_CNT_W-1:0];
				REG_TAPS:  cfg_q.tap_count        <= pwdata[TAP_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DECIM: prdata = DATA_W'(cfg_q.decimation_shift);
			REG_CHANS: prdata = DATA_W'(cfg_q.channel_count);
			REG_TAPS:  prdata = DATA_W'(cfg_q.tap_count);
			default:   prdata = '0;
		endcase
	end

endmodule

// File: design/fdm_mac.sv
// shared multiply-accumulate unit with rounding and saturation
module fdm_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fdm_pkg::mac_ctl_t                     ctl,
	input  logic signed [fdm_pkg::COEF_W-1:0]     tap_rd,
	input  logic signed [fdm_pkg::SAMPLE_W-1:0]   hist_rd,
	output logic                                  busy,
	output logic signed [fdm_pkg::SAMPLE_W-1:0]   rounded
);
	import fdm_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'(1) <<< (ROUND_SHIFT - 1);

	logic                     v_s1, v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  biased;
	logic signed [ACC_W-1:0]  shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= tap_rd * hist_rd;
		end
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign busy    = v_s1 || v_s2;
	assign biased  = acc_q + BIAS;
	assign shifted = biased >>> ROUND_SHIFT;

	always_comb begin
		if (shifted > SAT_HI) begin
			rounded = SAT_HI[SAMPLE_W-1:0];
		end else if (shifted < SAT_LO) begin
			rounded = SAT_LO[SAMPLE_W-1:0];
		end else begin
			rounded = shifted[SAMPLE_W-1:0];
		end
	end

endmodule
